[rtl/core/fppa_pkg.sv]
// Package for the partition allocator: sizes, codes, payload and control types.
package fppa_pkg;

	// Table geometry
	localparam int MAX_HOLES = 16;
	localparam int SIZE_BITS = 16;
	localparam int HOLE_BITS = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
	localparam int CNT_BITS  = $clog2(MAX_HOLES + 1);

	// Fixed field widths of the transactions
	localparam int OP_W     = 2;
	localparam int SEL_W    = 4;
	localparam int AMT_W    = 16;
	localparam int PIECES_W = 8;

	// Configuration register indexes
	localparam logic CFG_POLICY       = 1'b0;
	localparam logic CFG_HOLES_IN_USE = 1'b1;

	// Operation codes
	localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTORE = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE    = 2'd3;

	// Placement policy codes (the unused code behaves as first fit)
	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_BEST  = 2'd1;
	localparam logic [1:0] POL_WORST = 2'd2;

	localparam logic [PIECES_W-1:0] PIECES_MAX = '1;

	typedef logic [SIZE_BITS-1:0] size_t;
	typedef logic [HOLE_BITS-1:0] hole_idx_t;
	typedef logic [PIECES_W-1:0]  pieces_t;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [SEL_W-1:0] hole_select;
		logic [AMT_W-1:0] amount;
	} in_t;

	typedef struct packed {
		logic             granted;
		logic [SEL_W-1:0] chosen_hole;
		logic [AMT_W-1:0] left_over;
		pieces_t          pieces;
	} out_t;

	// Write controls from the sequencer to the hole table
	typedef struct packed {
		logic      load;
		hole_idx_t load_idx;
		size_t     load_val;
		logic      restore;
		logic      update;
		hole_idx_t upd_idx;
		size_t     upd_rem;
		pieces_t   upd_cnt;
	} tbl_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// Saturating piece count increment
	function automatic pieces_t pieces_inc(input pieces_t cnt);
		pieces_inc = (cnt == PIECES_MAX) ? cnt : cnt + pieces_t'(1);
	endfunction

endpackage

[rtl/core/fppa_hole_table.sv]
// Hole table: original size, remaining size and piece count of every hole.
module fppa_hole_table (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fppa_pkg::tbl_ctrl_t     ctrl,
	input  fppa_pkg::hole_idx_t     scan_idx,
	output fppa_pkg::size_t         scan_rem,
	input  fppa_pkg::hole_idx_t     pick_idx,
	output fppa_pkg::pieces_t       pick_cnt
);

	fppa_pkg::size_t   orig_q [fppa_pkg::MAX_HOLES];
	fppa_pkg::size_t   rem_q  [fppa_pkg::MAX_HOLES];
	fppa_pkg::pieces_t cnt_q  [fppa_pkg::MAX_HOLES];

	// Entry updates: load one hole, restore all, or take a placement
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < fppa_pkg::MAX_HOLES; j++) begin
				orig_q[j] <= '0;
				rem_q[j]  <= '0;
				cnt_q[j]  <= '0;
			end
		end else if (ctrl.load) begin
			orig_q[ctrl.load_idx] <= ctrl.load_val;
			rem_q[ctrl.load_idx]  <= ctrl.load_val;
			cnt_q[ctrl.load_idx]  <= '0;
		end else if (ctrl.restore) begin
			for (int j = 0; j < fppa_pkg::MAX_HOLES; j++) begin
				rem_q[j] <= orig_q[j];
				cnt_q[j] <= '0;
			end
		end else if (ctrl.update) begin
			rem_q[ctrl.upd_idx] <= ctrl.upd_rem;
			cnt_q[ctrl.upd_idx] <= ctrl.upd_cnt;
		end
	end

	// Read ports: one for the scan, one for the chosen hole
	assign scan_rem = rem_q[scan_idx];
	assign pick_cnt = cnt_q[pick_idx];

endmodule

[rtl/core/fit_policy_partition_allocator_top.sv]
// Top level of the partition allocator: sequencer, scan compare unit and output register.
//
// A transaction on the input channel is a load, an allocate or a restore. Loads,
// restores and unused codes pass from acceptance to the DONE state and are written
// to the result register once the output is free; the input then takes the next
// transaction. An allocate walks the table one hole per cycle through a single shared
// compare unit, and a closing step follows the last hole before the DONE state writes
// the result; holes_in_use is capped at sixteen holes searched, and first fit stops
// at the first hole that fits. The input is stalled while a transaction is in progress,
// and a finished result sits in an output register, so a waiting result only blocks
// the block once the next transaction has also finished. The user must write policy
// and holes_in_use through the configuration port only while the block is idle; the
// block itself does not enforce this.
module fit_policy_partition_allocator_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  fppa_pkg::in_t             in_data,
	output logic                      out_valid,
	input  logic                      out_stall,
	output fppa_pkg::out_t            out_data,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [4:0]                cfg_data
);

	fppa_pkg::state_t state_q, state_d;

	logic [1:0]                      policy_q;
	logic [4:0]                      holes_in_use_q;

	logic [fppa_pkg::OP_W-1:0]       op_q;
	logic [fppa_pkg::SEL_W-1:0]      sel_q;
	fppa_pkg::size_t                 amt_q;
	logic [fppa_pkg::CNT_BITS-1:0]   idx_q;
	logic                            found_q;
	fppa_pkg::hole_idx_t             pick_q;
	fppa_pkg::size_t                 best_q;

	logic                            out_valid_q;
	fppa_pkg::out_t                  out_data_q;

	fppa_pkg::tbl_ctrl_t             tbl_ctrl;
	fppa_pkg::size_t                 scan_rem;
	fppa_pkg::pieces_t               pick_cnt;

	logic                            in_accept;
	logic                            out_free;
	logic                            commit;
	logic [fppa_pkg::CNT_BITS-1:0]   n_holes;
	logic                            scan_live;
	logic                            fits;
	logic                            better;
	logic                            take;
	logic                            first_fit;
	logic                            scan_end;
	logic                            sel_ok;
	fppa_pkg::size_t                 new_rem;
	fppa_pkg::pieces_t               new_cnt;
	fppa_pkg::out_t                  res;

	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q       <= fppa_pkg::POL_FIRST;
			holes_in_use_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				fppa_pkg::CFG_POLICY:       policy_q       <= cfg_data[1:0];
				fppa_pkg::CFG_HOLES_IN_USE: holes_in_use_q <= cfg_data;
				default:                    ;
			endcase
		end
	end

	// Number of holes searched, capped at the table depth
	assign n_holes = (int'(holes_in_use_q) > fppa_pkg::MAX_HOLES)
		? fppa_pkg::CNT_BITS'(fppa_pkg::MAX_HOLES)
		: fppa_pkg::CNT_BITS'(holes_in_use_q);

	// Shared compare unit: one table entry per cycle
	assign first_fit = (policy_q != fppa_pkg::POL_BEST) && (policy_q != fppa_pkg::POL_WORST);
	assign scan_live = (idx_q != n_holes);
	assign fits      = (amt_q <= scan_rem);
	always_comb begin
		case (policy_q)
			fppa_pkg::POL_BEST:  better = (scan_rem < best_q);
			fppa_pkg::POL_WORST: better = (scan_rem > best_q);
			default:             better = 1'b0;
		endcase
	end
	assign take     = scan_live && fits && (!found_q || better);
	assign scan_end = !scan_live || (take && first_fit);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fppa_pkg::ST_IDLE: begin
				if (in_accept)
					state_d = (in_data.op == fppa_pkg::OP_ALLOC) ? fppa_pkg::ST_SCAN
					                                            : fppa_pkg::ST_DONE;
			end
			fppa_pkg::ST_SCAN: begin
				if (scan_end)
					state_d = fppa_pkg::ST_DONE;
			end
			fppa_pkg::ST_DONE: begin
				if (out_free)
					state_d = fppa_pkg::ST_IDLE;
			end
			default: state_d = fppa_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= fppa_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// Sequencer outputs
	always_comb begin
		in_stall = 1'b1;
		commit   = 1'b0;
		case (state_q)
			fppa_pkg::ST_IDLE: in_stall = 1'b0;
			fppa_pkg::ST_SCAN: ;
			fppa_pkg::ST_DONE: commit = out_free;
			default:           ;
		endcase
	end

	// Transaction and scan registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (in_accept) begin
			idx_q   <= '0;
			found_q <= 1'b0;
		end else if (state_q == fppa_pkg::ST_SCAN && scan_live) begin
			idx_q <= idx_q + fppa_pkg::CNT_BITS'(1);
			if (take)
				found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			op_q  <= in_data.op;
			sel_q <= in_data.hole_select;
			amt_q <= fppa_pkg::SIZE_BITS'(in_data.amount);
		end
		if (state_q == fppa_pkg::ST_SCAN && take) begin
			pick_q <= idx_q[fppa_pkg::HOLE_BITS-1:0];
			best_q <= scan_rem;
		end
	end

	// Result of the finished transaction
	assign sel_ok  = (int'(sel_q) < fppa_pkg::MAX_HOLES);
	assign new_rem = best_q - amt_q;
	assign new_cnt = fppa_pkg::pieces_inc(pick_cnt);

	always_comb begin
		res = '0;
		case (op_q)
			fppa_pkg::OP_LOAD: begin
				if (sel_ok) begin
					res.granted     = 1'b1;
					res.chosen_hole = sel_q;
					res.left_over   = fppa_pkg::AMT_W'(amt_q);
				end
			end
			fppa_pkg::OP_ALLOC: begin
				if (found_q) begin
					res.granted     = 1'b1;
					res.chosen_hole = fppa_pkg::SEL_W'(pick_q);
					res.left_over   = fppa_pkg::AMT_W'(new_rem);
					res.pieces      = new_cnt;
				end
			end
			fppa_pkg::OP_RESTORE: res.granted = 1'b1;
			default:              ;
		endcase
	end

	// Table writes happen together with the result hand-off
	always_comb begin
		tbl_ctrl          = '0;
		tbl_ctrl.load_idx = fppa_pkg::HOLE_BITS'(sel_q);
		tbl_ctrl.load_val = amt_q;
		tbl_ctrl.upd_idx  = pick_q;
		tbl_ctrl.upd_rem  = new_rem;
		tbl_ctrl.upd_cnt  = new_cnt;
		tbl_ctrl.load     = commit && (op_q == fppa_pkg::OP_LOAD) && sel_ok;
		tbl_ctrl.restore  = commit && (op_q == fppa_pkg::OP_RESTORE);
		tbl_ctrl.update   = commit && (op_q == fppa_pkg::OP_ALLOC) && found_q;
	end

	fppa_hole_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (tbl_ctrl),
		.scan_idx (idx_q[fppa_pkg::HOLE_BITS-1:0]),
		.scan_rem (scan_rem),
		.pick_idx (pick_q),
		.pick_cnt (pick_cnt)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (commit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (commit)
			out_data_q <= res;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[sim/tb_fit_policy_partition_allocator_top.sv]
// Testbench for the partition allocator: directed and random transactions checked against a hole-table model.
`timescale 1ns / 1ps

module tb_fit_policy_partition_allocator_top;
	import fppa_pkg::*;

	localparam int unsigned RUN_LIMIT_NS = 10_000_000;
	localparam int          MAX_REPORTS  = 10;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid = 1'b0;
	logic       in_stall;
	in_t        in_data = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_t       out_data;
	logic       cfg_we = 1'b0;
	logic       cfg_index = 1'b0;
	logic [4:0] cfg_data = '0;

	// Hole table as the block should hold it
	logic [SIZE_BITS-1:0] hole_orig [MAX_HOLES];
	logic [SIZE_BITS-1:0] hole_rem  [MAX_HOLES];
	logic [PIECES_W-1:0]  hole_pcs  [MAX_HOLES];
	logic [1:0]           cur_policy;
	logic [4:0]           cur_holes;

	out_t pending_grants[$];
	int   err_count    = 0;
	bit   quiet_input  = 1'b0;
	bit   quiet_output = 1'b0;

	fit_policy_partition_allocator_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Apply one transaction to the hole table and return the result it should give
	function automatic out_t apply_to_hole_table(input in_t item);
		out_t                 res;
		int                   span;
		int                   pick;
		bit                   found;
		logic [SIZE_BITS-1:0] amt;
		res = '0;
		amt = item.amount[SIZE_BITS-1:0];
		case (item.op)
			OP_LOAD: begin
				hole_orig[item.hole_select] = amt;
				hole_rem[item.hole_select]  = amt;
				hole_pcs[item.hole_select]  = '0;
				res.granted     = 1'b1;
				res.chosen_hole = item.hole_select;
				res.left_over   = amt;
			end
			OP_RESTORE: begin
				for (int j = 0; j < MAX_HOLES; j++) begin
					hole_rem[j] = hole_orig[j];
					hole_pcs[j] = '0;
				end
				res.granted = 1'b1;
			end
			OP_ALLOC: begin
				span  = (cur_holes > MAX_HOLES) ? MAX_HOLES : cur_holes;
				found = 1'b0;
				pick  = 0;
				for (int j = 0; j < span; j++) begin
					if (amt <= hole_rem[j]) begin
						if (!found) begin
							found = 1'b1;
							pick  = j;
							// first fit, and the unused policy code, stop here
							if (cur_policy != POL_BEST && cur_policy != POL_WORST)
								break;
						end else if (cur_policy == POL_BEST && hole_rem[j] < hole_rem[pick]) begin
							pick = j;
						end else if (cur_policy == POL_WORST && hole_rem[j] > hole_rem[pick]) begin
							pick = j;
						end
					end
				end
				if (found) begin
					hole_rem[pick] = hole_rem[pick] - amt;
					if (hole_pcs[pick] != PIECES_MAX)
						hole_pcs[pick] = hole_pcs[pick] + 1'b1;
					res.granted     = 1'b1;
					res.chosen_hole = pick[SEL_W-1:0];
					res.left_over   = hole_rem[pick];
					res.pieces      = hole_pcs[pick];
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic logic [AMT_W-1:0] pick_hole_size();
		case ($urandom_range(0, 3))
			0:       return AMT_W'($urandom);
			1:       return AMT_W'($urandom_range(0, 1023));
			2:       return $urandom_range(0, 1) ? '1 : '0;
			default: return AMT_W'($urandom_range(1024, 16383));
		endcase
	endfunction

	function automatic logic [AMT_W-1:0] pick_request_size();
		case ($urandom_range(0, 4))
			0:       return AMT_W'($urandom);
			1:       return AMT_W'($urandom_range(0, 511));
			2:       return hole_rem[$urandom_range(0, MAX_HOLES - 1)];
			3:       return '0;
			default: return AMT_W'($urandom_range(512, 8191));
		endcase
	endfunction

	// Send one transaction; returns at the edge where it was taken
	task automatic send_item(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] sel,
			input logic [AMT_W-1:0] amt);
		int   gap;
		in_t  item;
		item = '{op: op, hole_select: sel, amount: amt};
		gap  = quiet_input ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		pending_grants.push_back(apply_to_hole_table(item));
	endtask

	// Hold off input until every pending result has been taken
	task automatic settle_block();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_grants.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [4:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_POLICY)
			cur_policy = val[1:0];
		else
			cur_holes = val;
		@(posedge clk);
	endtask

	// Registers still at reset: no hole in the search, so a request is refused
	task automatic test_reset_state();
		send_item(OP_ALLOC, 4'd0, 16'h0000);
		send_item(OP_NONE, 4'hF, 16'hFFFF);
		send_item(OP_RESTORE, 4'h0, 16'h0000);
		send_item(OP_LOAD, 4'hF, 16'hFFFF);
	endtask

	// Each policy, zero and full-size requests, ties, restore and holes_in_use extremes
	task automatic test_directed();
		settle_block();
		write_reg(CFG_HOLES_IN_USE, 5'd16);
		write_reg(CFG_POLICY, 5'(POL_FIRST));
		send_item(OP_LOAD, 4'd0, 16'd100);
		send_item(OP_LOAD, 4'd3, 16'd100);
		send_item(OP_LOAD, 4'd5, 16'h5555);
		send_item(OP_LOAD, 4'd10, 16'hAAAA);
		send_item(OP_LOAD, 4'd15, 16'hFFFF);
		send_item(OP_ALLOC, 4'd0, 16'h0000);
		send_item(OP_ALLOC, 4'd0, 16'hFFFF);
		send_item(OP_ALLOC, 4'd0, 16'hFFFF);
		settle_block();
		write_reg(CFG_POLICY, 5'(POL_BEST));
		send_item(OP_ALLOC, 4'd0, 16'd50);
		settle_block();
		write_reg(CFG_POLICY, 5'(POL_WORST));
		send_item(OP_ALLOC, 4'd0, 16'd1);
		settle_block();
		write_reg(CFG_POLICY, 5'd3);
		send_item(OP_ALLOC, 4'd0, 16'd1);
		send_item(OP_NONE, 4'h5, 16'h5A5A);
		send_item(OP_RESTORE, 4'hA, 16'hA5A5);
		settle_block();
		write_reg(CFG_HOLES_IN_USE, 5'd31);
		write_reg(CFG_POLICY, 5'(POL_FIRST));
		send_item(OP_ALLOC, 4'd0, 16'hFFFF);
		settle_block();
		write_reg(CFG_HOLES_IN_USE, 5'd1);
		send_item(OP_ALLOC, 4'd0, 16'd101);
	endtask

	// Enough tiny requests into one hole to push its piece count past saturation
	task automatic test_piece_saturation();
		settle_block();
		write_reg(CFG_HOLES_IN_USE, 5'd1);
		write_reg(CFG_POLICY, 5'(POL_FIRST));
		send_item(OP_LOAD, 4'd0, 16'hFFFF);
		repeat (270) send_item(OP_ALLOC, 4'(AMT_W'($urandom)), 16'($urandom_range(0, 1)));
		send_item(OP_RESTORE, 4'd0, 16'd0);
		send_item(OP_ALLOC, 4'd0, 16'd1);
	endtask

	// Phases: fill the table, then mostly requests with some reloads, restores and no-ops
	task automatic test_random();
		int hiu;
		int roll;
		for (int ph = 0; ph < 15; ph++) begin
			settle_block();
			quiet_input  = ($urandom_range(0, 3) == 0);
			quiet_output = ($urandom_range(0, 3) == 0);
			case (ph)
				0:       hiu = 0;
				1:       hiu = 16;
				2:       hiu = 31;
				3:       hiu = 1;
				4:       hiu = 17;
				default: hiu = $urandom_range(0, 1) ? 16 : $urandom_range(0, 31);
			endcase
			write_reg(CFG_POLICY, 5'(ph % 4));
			write_reg(CFG_HOLES_IN_USE, 5'(hiu));
			for (int h = 0; h < MAX_HOLES; h++)
				send_item(OP_LOAD, 4'(h), pick_hole_size());
			repeat (66) begin
				roll = $urandom_range(0, 99);
				if (roll < 70)
					send_item(OP_ALLOC, 4'($urandom), pick_request_size());
				else if (roll < 85)
					send_item(OP_LOAD, 4'($urandom), pick_hole_size());
				else if (roll < 93)
					send_item(OP_RESTORE, 4'($urandom), 16'($urandom));
				else
					send_item(OP_NONE, 4'($urandom), 16'($urandom));
			end
		end
		quiet_input  = 1'b0;
		quiet_output = 1'b0;
	endtask

	// Output side: random stall per transaction, compare each result with the oldest expectation
	initial begin : result_check
		int   hold;
		out_t want;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			hold = quiet_output ? 0 : $urandom_range(0, 7);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (out_valid !== 1'b1) @(posedge clk);
			if (pending_grants.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("%0t: unexpected result g=%0b hole=%0d left=%0h pcs=%0d", $time,
						out_data.granted, out_data.chosen_hole, out_data.left_over,
						out_data.pieces);
			end else begin
				want = pending_grants.pop_front();
				if (out_data.granted !== want.granted || out_data.chosen_hole !== want.chosen_hole ||
						out_data.left_over !== want.left_over || out_data.pieces !== want.pieces) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("%0t: mismatch exp g=%0b hole=%0d left=%0h pcs=%0d, got g=%0b hole=%0d left=%0h pcs=%0d",
							$time, want.granted, want.chosen_hole, want.left_over, want.pieces,
							out_data.granted, out_data.chosen_hole, out_data.left_over,
							out_data.pieces);
				end
			end
		end
	end

	// Run limit
	initial begin
		#(RUN_LIMIT_NS);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		for (int j = 0; j < MAX_HOLES; j++) begin
			hole_orig[j] = '0;
			hole_rem[j]  = '0;
			hole_pcs[j]  = '0;
		end
		cur_policy = POL_FIRST;
		cur_holes  = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_directed();
		test_piece_saturation();
		test_random();
		settle_block();
		repeat (30) @(posedge clk);
		if (pending_grants.size() != 0)
			err_count++;
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
